### hdl/mvnb_pkg.sv
`timescale 1ns / 1ps

package mvnb_pkg;

  // Default number of vertices in each store.
  localparam int unsigned VERTEX_COUNT_DEF = 1024;

  // Field widths.
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned NRM_W   = 16;
  localparam int unsigned ENTRY_W = 3 * COORD_W;

  // Normalizer input width: wide enough for a cross product component.
  localparam int unsigned VEC_W  = 36;
  // Magnitudes are scaled below 2^MAG_W before squaring.
  localparam int unsigned MAG_W  = 30;
  // Fraction bits of a Q1.14 normal.
  localparam int unsigned FRAC_W = 14;
  // Quotient bits of one normalized component (magnitude at most 2^FRAC_W).
  localparam int unsigned QUO_W  = FRAC_W + 1;

  typedef logic signed [VEC_W-1:0] norm_vec_t [3];
  typedef logic signed [NRM_W-1:0] nrm_vec_t [3];

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TRIANGLE = 2'd1,
    CMD_READ     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SQUARE,
    NS_ROOT,
    NS_DIV_INIT,
    NS_DIVIDE
  } norm_state_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_VREAD,
    ST_CROSS,
    ST_FACE_START,
    ST_FACE_WAIT,
    ST_CORNER_RD,
    ST_CORNER_CHK,
    ST_CORNER_NORM,
    ST_FINISH
  } mvnb_state_e;

endpackage

### hdl/mvnb_ram.sv
`timescale 1ns / 1ps

module mvnb_ram #(
  parameter int unsigned Width = mvnb_pkg::ENTRY_W,
  parameter int unsigned Depth = mvnb_pkg::VERTEX_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/mvnb_norm.sv
`timescale 1ns / 1ps

module mvnb_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mvnb_pkg::norm_vec_t vec_i,
  output logic                done_o,
  output mvnb_pkg::nrm_vec_t  res_o
);

  localparam int unsigned AbsW     = mvnb_pkg::VEC_W;
  localparam int unsigned MagW     = mvnb_pkg::MAG_W;
  localparam int unsigned ShiftMax = AbsW - MagW;
  localparam int unsigned ShW      = $clog2(ShiftMax + 1);
  localparam int unsigned SqW      = 2 * MagW;
  localparam int unsigned AccW     = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned FracW    = mvnb_pkg::FRAC_W;
  localparam int unsigned QuoW     = mvnb_pkg::QUO_W;
  localparam int unsigned NumW     = MagW + FracW + 1;
  localparam int unsigned ResW     = mvnb_pkg::NRM_W;

  mvnb_pkg::norm_state_e state_q, state_d;
  logic [3:0]            cnt_q, cnt_d;
  logic [MagW-1:0]       mag_q [3];
  logic [MagW-1:0]       mag_d [3];
  logic [2:0]            neg_q, neg_d;
  logic [SqW-1:0]        sq_q, sq_d;
  logic [AccW-1:0]       x_q, x_d;
  logic [AccW-1:0]       root_q, root_d;
  logic [AccW-1:0]       bit_q, bit_d;
  logic [NumW-1:0]       rem_q [3];
  logic [NumW-1:0]       rem_d [3];
  logic [NumW-1:0]       dsh_q, dsh_d;
  logic [QuoW-1:0]       quo_q [3];
  logic [QuoW-1:0]       quo_d [3];
  mvnb_pkg::nrm_vec_t    res_q, res_d;
  logic                  done_q, done_d;

  logic [2:0]            sgn;
  logic [AbsW-1:0]       absv [3];
  logic [AbsW-1:0]       mx;
  logic [ShW-1:0]        shamt;
  logic [MagW-1:0]       sq_sel;
  logic [AccW-1:0]       root_try;
  logic [RootW-1:0]      len;
  logic [QuoW-1:0]       qn [3];
  logic [2:0]            ge;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    sq_d    = sq_q;
    x_d     = x_q;
    root_d  = root_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    res_d   = res_q;
    done_d  = 1'b0;

    // Magnitudes and the common right shift that brings the largest below 2^MagW.
    for (int i = 0; i < 3; i++) begin
      sgn[i]  = vec_i[i][AbsW-1];
      absv[i] = sgn[i] ? (~AbsW'(vec_i[i]) + AbsW'(1)) : AbsW'(vec_i[i]);
    end
    mx = absv[0];
    if (absv[1] > mx) mx = absv[1];
    if (absv[2] > mx) mx = absv[2];
    shamt = '0;
    for (int s = ShiftMax; s >= 0; s--) begin
      if (((mx >> s) >> MagW) == '0) shamt = ShW'(s);
    end

    case (cnt_q[1:0])
      2'd0:    sq_sel = mag_q[0];
      2'd1:    sq_sel = mag_q[1];
      default: sq_sel = mag_q[2];
    endcase

    root_try = root_q + bit_q;
    len      = root_q[RootW-1:0];

    for (int i = 0; i < 3; i++) begin
      ge[i] = rem_q[i] >= dsh_q;
      qn[i] = {quo_q[i][QuoW-2:0], ge[i]};
    end

    unique case (state_q)
      mvnb_pkg::NS_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            mag_d[i] = MagW'(absv[i] >> shamt);
          end
          neg_d   = sgn;
          cnt_d   = '0;
          x_d     = '0;
          state_d = mvnb_pkg::NS_SQUARE;
        end
      end
      mvnb_pkg::NS_SQUARE: begin
        // Square one lane per cycle; each square is registered and added to the sum in the cycle after.
        if (cnt_q[1:0] != 2'd3) sq_d = SqW'(sq_sel) * SqW'(sq_sel);
        if (cnt_q[1:0] != 2'd0) x_d = x_q + AccW'(sq_q);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q[1:0] == 2'd3) begin
          root_d  = '0;
          bit_d   = AccW'(1) << (AccW - 2);
          state_d = mvnb_pkg::NS_ROOT;
        end
      end
      mvnb_pkg::NS_ROOT: begin
        if (x_q >= root_try) begin
          x_d    = x_q - root_try;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) state_d = mvnb_pkg::NS_DIV_INIT;
      end
      mvnb_pkg::NS_DIV_INIT: begin
        if (len == '0) begin
          for (int i = 0; i < 3; i++) res_d[i] = '0;
          done_d  = 1'b1;
          state_d = mvnb_pkg::NS_IDLE;
        end else begin
          for (int i = 0; i < 3; i++) begin
            rem_d[i] = (NumW'(mag_q[i]) << FracW) + NumW'(len >> 1);
            quo_d[i] = '0;
          end
          dsh_d   = NumW'(len) << FracW;
          cnt_d   = '0;
          state_d = mvnb_pkg::NS_DIVIDE;
        end
      end
      mvnb_pkg::NS_DIVIDE: begin
        // Restoring division, one quotient bit per cycle in each lane.
        for (int i = 0; i < 3; i++) begin
          if (ge[i]) rem_d[i] = rem_q[i] - dsh_q;
          quo_d[i] = qn[i];
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(QuoW - 1)) begin
          for (int i = 0; i < 3; i++) begin
            res_d[i] = neg_q[i] ? (ResW'(0) - ResW'(qn[i])) : ResW'(qn[i]);
          end
          done_d  = 1'b1;
          state_d = mvnb_pkg::NS_IDLE;
        end
      end
      default: state_d = mvnb_pkg::NS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvnb_pkg::NS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    sq_q   <= sq_d;
    x_q    <= x_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/mesh_vertex_normal_builder.sv
`timescale 1ns / 1ps

// Per-vertex normal builder.
// Requests arrive on the input channel (in_valid_i / in_stall_o); each request
// produces exactly one result request on the output channel (out_valid_o /
// out_stall_i). A write request stores a vertex position and clears its normal,
// a triangle request returns the unit face normal and folds it into the stored
// normals of its three corners, and a read request returns one stored normal.
// The block works on one request at a time. Write and unused requests go from
// acceptance straight to the finish state, a read passes a wait state for the
// memory first. A triangle takes longer when corners need renormalizing, since
// its time rests mostly on the bit-serial normalizer, which squares, takes the
// square root and then divides on each use.
// After reset the normal memory is swept to zero, one entry per cycle, and the
// input stays stalled until the sweep is done. A finished result waits in the
// output register while the receiver stalls; the next request is accepted
// meanwhile and only its own result waits for the register to free up.
module mesh_vertex_normal_builder #(
  parameter int unsigned VERTEX_COUNT = mvnb_pkg::VERTEX_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [mvnb_pkg::IDX_W-1:0]          index_a_i,
  input  logic [mvnb_pkg::IDX_W-1:0]          index_b_i,
  input  logic [mvnb_pkg::IDX_W-1:0]          index_c_i,
  input  logic signed [mvnb_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [mvnb_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [mvnb_pkg::COORD_W-1:0] pos_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mvnb_pkg::NRM_W-1:0]   normal_x_o,
  output logic signed [mvnb_pkg::NRM_W-1:0]   normal_y_o,
  output logic signed [mvnb_pkg::NRM_W-1:0]   normal_z_o
);

  localparam int unsigned AddrW  = $clog2(VERTEX_COUNT);
  localparam int unsigned CmpW   = 17;
  localparam int unsigned IdxW   = mvnb_pkg::IDX_W;
  localparam int unsigned CoordW = mvnb_pkg::COORD_W;
  localparam int unsigned NrmW   = mvnb_pkg::NRM_W;
  localparam int unsigned EntryW = mvnb_pkg::ENTRY_W;
  localparam int unsigned VecW   = mvnb_pkg::VEC_W;
  localparam int unsigned EdgeW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * EdgeW;
  localparam int unsigned CrossW = ProdW + 1;

  function automatic logic idx_ok(logic [IdxW-1:0] idx);
    return CmpW'(idx) < CmpW'(VERTEX_COUNT);
  endfunction

  function automatic logic [AddrW-1:0] to_addr(logic [IdxW-1:0] idx);
    logic [CmpW-1:0] wide;
    wide = CmpW'(idx);
    return wide[AddrW-1:0];
  endfunction

  mvnb_pkg::mvnb_state_e state_q, state_d;
  logic [1:0]               cnt_q, cnt_d;
  logic [AddrW-1:0]         clr_q, clr_d;
  logic [IdxW-1:0]          idx_q [3];
  logic [IdxW-1:0]          idx_d [3];
  logic [2:0]               ok_q, ok_d;
  logic signed [CoordW-1:0] p_q [3][3];
  logic signed [CoordW-1:0] p_d [3][3];
  logic signed [ProdW-1:0]  prod_a_q, prod_a_d, prod_b_q, prod_b_d;
  logic signed [CrossW-1:0] cr_q [3];
  logic signed [CrossW-1:0] cr_d [3];
  mvnb_pkg::nrm_vec_t       face_q, face_d;
  mvnb_pkg::nrm_vec_t       res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [NrmW-1:0]   out_x_q, out_y_q, out_z_q;

  logic                     vram_we, nram_we;
  logic [AddrW-1:0]         vram_waddr, vram_raddr, nram_waddr, nram_raddr;
  logic [EntryW-1:0]        vram_wdata, vram_rdata, nram_wdata, nram_rdata;

  logic                     norm_start, norm_done;
  mvnb_pkg::norm_vec_t      norm_vec;
  mvnb_pkg::nrm_vec_t       norm_res;

  logic signed [EdgeW-1:0]  e1 [3];
  logic signed [EdgeW-1:0]  e2 [3];
  mvnb_pkg::nrm_vec_t       stored;
  logic [IdxW-1:0]          cur_idx;
  logic                     cur_ok;
  logic [AddrW-1:0]         cur_addr;
  logic [1:0]               prev;
  logic                     advance, out_free, out_load;

  mvnb_ram #(.Width(EntryW), .Depth(VERTEX_COUNT)) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  mvnb_ram #(.Width(EntryW), .Depth(VERTEX_COUNT)) u_normal_ram (
    .clk_i   (clk_i),
    .we_i    (nram_we),
    .waddr_i (nram_waddr),
    .wdata_i (nram_wdata),
    .raddr_i (nram_raddr),
    .rdata_o (nram_rdata)
  );

  mvnb_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  // Edge vectors b - a and c - a of the current triangle, the unpacked stored normal and the current corner.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = EdgeW'(p_q[1][i]) - EdgeW'(p_q[0][i]);
      e2[i] = EdgeW'(p_q[2][i]) - EdgeW'(p_q[0][i]);
    end
    stored[0] = nram_rdata[3*NrmW-1:2*NrmW];
    stored[1] = nram_rdata[2*NrmW-1:NrmW];
    stored[2] = nram_rdata[NrmW-1:0];
    case (cnt_q)
      2'd0:    cur_idx = idx_q[0];
      2'd1:    cur_idx = idx_q[1];
      default: cur_idx = idx_q[2];
    endcase
    case (cnt_q)
      2'd0:    cur_ok = ok_q[0];
      2'd1:    cur_ok = ok_q[1];
      default: cur_ok = ok_q[2];
    endcase
    cur_addr = to_addr(cur_idx);
    prev     = cnt_q - 2'd1;
    out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    idx_d    = idx_q;
    ok_d     = ok_q;
    p_d      = p_q;
    prod_a_d = prod_a_q;
    prod_b_d = prod_b_q;
    cr_d     = cr_q;
    face_d   = face_q;
    res_d    = res_q;

    in_stall_o = 1'b1;
    vram_we    = 1'b0;
    vram_waddr = to_addr(index_a_i);
    vram_wdata = {pos_x_i, pos_y_i, pos_z_i};
    vram_raddr = cur_addr;
    nram_we    = 1'b0;
    nram_waddr = cur_addr;
    nram_wdata = '0;
    nram_raddr = cur_addr;
    norm_start = 1'b0;
    advance    = 1'b0;
    out_load   = 1'b0;

    // The normalizer sees either the raw cross product or the sum of the
    // stored normal and the face normal.
    for (int i = 0; i < 3; i++) begin
      if (state_q == mvnb_pkg::ST_FACE_START) begin
        norm_vec[i] = VecW'(cr_q[i]);
      end else begin
        norm_vec[i] = VecW'(stored[i]) + VecW'(face_q[i]);
      end
    end

    unique case (state_q)
      mvnb_pkg::ST_CLEAR: begin
        nram_we    = 1'b1;
        nram_waddr = clr_q;
        clr_d      = clr_q + AddrW'(1);
        if (clr_q == AddrW'(VERTEX_COUNT - 1)) state_d = mvnb_pkg::ST_IDLE;
      end
      mvnb_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          idx_d[0] = index_a_i;
          idx_d[1] = index_b_i;
          idx_d[2] = index_c_i;
          ok_d     = {idx_ok(index_c_i), idx_ok(index_b_i), idx_ok(index_a_i)};
          cnt_d    = '0;
          for (int i = 0; i < 3; i++) res_d[i] = '0;
          unique case (mvnb_pkg::cmd_e'(command_i))
            mvnb_pkg::CMD_WRITE: begin
              vram_we    = idx_ok(index_a_i);
              nram_we    = idx_ok(index_a_i);
              nram_waddr = to_addr(index_a_i);
              state_d    = mvnb_pkg::ST_FINISH;
            end
            mvnb_pkg::CMD_TRIANGLE: state_d = mvnb_pkg::ST_VREAD;
            mvnb_pkg::CMD_READ: begin
              nram_raddr = to_addr(index_a_i);
              state_d    = mvnb_pkg::ST_READ_WAIT;
            end
            mvnb_pkg::CMD_NONE: state_d = mvnb_pkg::ST_FINISH;
          endcase
        end
      end
      mvnb_pkg::ST_READ_WAIT: begin
        for (int i = 0; i < 3; i++) res_d[i] = ok_q[0] ? stored[i] : '0;
        state_d = mvnb_pkg::ST_FINISH;
      end
      mvnb_pkg::ST_VREAD: begin
        // Reads go out for corners 0..2; each returns in the cycle after.
        if (cnt_q != 2'd0) begin
          p_d[prev][0] = ok_q[prev] ? vram_rdata[3*CoordW-1:2*CoordW] : '0;
          p_d[prev][1] = ok_q[prev] ? vram_rdata[2*CoordW-1:CoordW] : '0;
          p_d[prev][2] = ok_q[prev] ? vram_rdata[CoordW-1:0] : '0;
        end
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = mvnb_pkg::ST_CROSS;
      end
      mvnb_pkg::ST_CROSS: begin
        // One cross product component per cycle: two products, then their difference.
        case (cnt_q)
          2'd0: begin
            prod_a_d = e1[1] * e2[2];
            prod_b_d = e1[2] * e2[1];
          end
          2'd1: begin
            prod_a_d = e1[2] * e2[0];
            prod_b_d = e1[0] * e2[2];
          end
          2'd2: begin
            prod_a_d = e1[0] * e2[1];
            prod_b_d = e1[1] * e2[0];
          end
          default: ;
        endcase
        if (cnt_q != 2'd0) cr_d[prev] = CrossW'(prod_a_q) - CrossW'(prod_b_q);
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = mvnb_pkg::ST_FACE_START;
      end
      mvnb_pkg::ST_FACE_START: begin
        norm_start = 1'b1;
        state_d    = mvnb_pkg::ST_FACE_WAIT;
      end
      mvnb_pkg::ST_FACE_WAIT: begin
        if (norm_done) begin
          face_d  = norm_res;
          cnt_d   = '0;
          state_d = mvnb_pkg::ST_CORNER_RD;
        end
      end
      mvnb_pkg::ST_CORNER_RD: begin
        // Out-of-range corners are skipped without touching the memory.
        if (cur_ok) begin
          state_d = mvnb_pkg::ST_CORNER_CHK;
        end else begin
          advance = 1'b1;
        end
      end
      mvnb_pkg::ST_CORNER_CHK: begin
        if (nram_rdata == '0) begin
          nram_we    = 1'b1;
          nram_wdata = {face_q[0], face_q[1], face_q[2]};
          advance    = 1'b1;
        end else if (nram_rdata == {face_q[0], face_q[1], face_q[2]}) begin
          advance = 1'b1;
        end else begin
          norm_start = 1'b1;
          state_d    = mvnb_pkg::ST_CORNER_NORM;
        end
      end
      mvnb_pkg::ST_CORNER_NORM: begin
        if (norm_done) begin
          nram_we    = 1'b1;
          nram_wdata = {norm_res[0], norm_res[1], norm_res[2]};
          advance    = 1'b1;
        end
      end
      mvnb_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = mvnb_pkg::ST_IDLE;
        end
      end
      default: state_d = mvnb_pkg::ST_IDLE;
    endcase

    // Corners are updated strictly in order, so a repeated corner reads back
    // what the earlier update wrote.
    if (advance) begin
      if (cnt_q == 2'd2) begin
        res_d   = face_q;
        state_d = mvnb_pkg::ST_FINISH;
      end else begin
        cnt_d   = cnt_q + 2'd1;
        state_d = mvnb_pkg::ST_CORNER_RD;
      end
    end

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvnb_pkg::ST_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ok_q     <= ok_d;
    p_q      <= p_d;
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    cr_q     <= cr_d;
    face_q   <= face_d;
    res_q    <= res_d;
    if (out_load) begin
      out_x_q <= res_q[0];
      out_y_q <= res_q[1];
      out_z_q <= res_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = out_x_q;
  assign normal_y_o  = out_y_q;
  assign normal_z_o  = out_z_q;

  // The normalizer only finishes while the sequencer is waiting for it.
  a_norm_done_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> (state_q == mvnb_pkg::ST_FACE_WAIT || state_q == mvnb_pkg::ST_CORNER_NORM))
    else $error("normalizer finished while no one was waiting");

  // No request is taken while the normal memory is still being cleared.
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mvnb_pkg::ST_CLEAR |-> in_stall_o)
    else $error("request accepted during the clearing pass");

  // A result never overwrites one the receiver has not taken (checked on the x and z components).
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_x_q) && $stable(out_z_q))
    else $error("pending result overwritten");

  // Corner updates write only vertices inside the store.
  a_corner_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nram_we && (state_q == mvnb_pkg::ST_CORNER_CHK || state_q == mvnb_pkg::ST_CORNER_NORM)
      |-> cur_ok)
    else $error("normal write to an out-of-range corner");

endmodule
